// File: rtl/wvm_pkg.sv
// wvm_pkg: codes, widths and interface types shared by the wavetable voice mixer
// no dependencies; referenced by scoped name from every rtl file
package wvm_pkg;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_REG_WR  = 2'd1;
    localparam logic [1:0] FUNC_ENABLE  = 2'd2;
    localparam logic [1:0] FUNC_WAVE_LD = 2'd3;

    localparam logic [1:0] CFG_MAP_MODE    = 2'd0;
    localparam logic [1:0] CFG_VOICE_COUNT = 2'd1;
    localparam logic [1:0] CFG_MIX_GAIN    = 2'd2;

    localparam logic MAP_NIBBLE = 1'b0;

    localparam logic       RST_MAP_MODE    = 1'b0;
    localparam logic [3:0] RST_VOICE_COUNT = 4'd3;
    localparam logic [7:0] RST_MIX_GAIN    = 8'd32;

    localparam int WAVE_W     = 4;
    localparam int PHASE_W    = 20;
    localparam int SUM_W      = 16;
    localparam int PROD_W     = 12;
    localparam int VCNT_W     = 4;
    localparam int REG_ADDR_W = 7;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  sum;
        logic [VCNT_W-1:0]        voices;
        logic [7:0]               gain;
    } scl_req_t;

    typedef struct packed {
        logic              done;
        logic signed [7:0] sample;
    } scl_rsp_t;

endpackage

// File: rtl/wvm_sound_regs.sv
// wvm_sound_regs: sound register memory, one write port and two registered read ports
// entries read as zero until written or when beyond the register count; uses wvm_pkg
module wvm_sound_regs #(
    parameter int REG_COUNT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wvm_pkg::mem_wr_t                  wr,
    input  logic [wvm_pkg::REG_ADDR_W-1:0]    raddr_a,
    input  logic [wvm_pkg::REG_ADDR_W-1:0]    raddr_b,
    output logic [7:0]                        rdata_a,
    output logic [7:0]                        rdata_b
);

    localparam int RAW = $clog2(REG_COUNT);

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           data_a_reg;
    logic [7:0]           data_b_reg;
    logic                 ok_a_reg;
    logic                 ok_b_reg;
    logic                 wr_hit;
    logic                 a_in;
    logic                 b_in;

    assign wr_hit = wr.en && ({1'b0, wr.addr} < 9'(REG_COUNT));
    assign a_in   = {1'b0, raddr_a} < 8'(REG_COUNT);
    assign b_in   = {1'b0, raddr_b} < 8'(REG_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr.addr[RAW-1:0]] <= wr.data;
        end
        data_a_reg <= mem[raddr_a[RAW-1:0]];
        data_b_reg <= mem[raddr_b[RAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr.addr[RAW-1:0]] <= 1'b1;
            end
            ok_a_reg <= a_in && valid_reg[raddr_a[RAW-1:0]];
            ok_b_reg <= b_in && valid_reg[raddr_b[RAW-1:0]];
        end
    end

    assign rdata_a = ok_a_reg ? data_a_reg : 8'h00;
    assign rdata_b = ok_b_reg ? data_b_reg : 8'h00;

endmodule

// File: rtl/wvm_wave_mem.sv
// wvm_wave_mem: 4-bit wave sample memory, one write port and one registered read port
// entries read as zero until loaded; uses wvm_pkg
module wvm_wave_mem #(
    parameter int WAVE_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wvm_pkg::mem_wr_t                    wr,
    input  logic [$clog2(WAVE_ENTRIES)-1:0]     raddr,
    output logic [wvm_pkg::WAVE_W-1:0]          rdata
);

    localparam int WAW = $clog2(WAVE_ENTRIES);

    logic [wvm_pkg::WAVE_W-1:0] mem [WAVE_ENTRIES];
    logic [WAVE_ENTRIES-1:0]    valid_reg;
    logic [wvm_pkg::WAVE_W-1:0] data_reg;
    logic                       ok_reg;
    logic                       wr_hit;

    assign wr_hit = wr.en && ({1'b0, wr.addr} < 9'(WAVE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr.addr[WAW-1:0]] <= wr.data[wvm_pkg::WAVE_W-1:0];
        end
        data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr.addr[WAW-1:0]] <= 1'b1;
            end
            ok_reg <= valid_reg[raddr];
        end
    end

    assign rdata = ok_reg ? data_reg : '0;

endmodule

// File: rtl/wvm_scaler.sv
// wvm_scaler: saturates the voice sum, applies the gain and divides by voices*16
// bit-serial restoring divider, seven quotient bits; uses wvm_pkg
module wvm_scaler (
    input  logic              clk,
    input  logic              rst_n,
    input  wvm_pkg::scl_req_t req,
    output wvm_pkg::scl_rsp_t rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROD  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [6:0] SAT_MAX  = 7'd127;
    localparam logic [2:0] DIV_LAST = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [2:0]  cnt_reg;
    logic        neg_reg;
    logic [9:0]  magc_reg;
    logic [3:0]  voices_reg;
    logic [7:0]  gain_reg;
    logic [17:0] prod_reg;
    logic [2:0]  rem_reg;
    logic [6:0]  dvd_reg;
    logic [6:0]  quo_reg;

    logic [15:0] mag;
    logic [10:0] limit;
    logic [9:0]  magc_in;
    logic [13:0] x_val;
    logic        over;
    logic [3:0]  trial;
    logic        fits;

    always_comb
    begin
        mag     = req.sum[wvm_pkg::SUM_W-1] ? 16'(-req.sum) : 16'(req.sum);
        limit   = {req.voices, 7'b0};
        magc_in = (mag >= 16'(limit)) ? 10'(limit - 11'd1) : mag[9:0];
        x_val   = prod_reg[17:4];
        over    = x_val >= 14'({voices_reg, 7'b0});
        trial   = {rem_reg, dvd_reg[6]};
        fits    = trial >= voices_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req.start) state_next = S_PROD;
            S_PROD:  state_next = S_CHECK;
            S_CHECK: state_next = over ? S_DONE : S_DIV;
            S_DIV:   if (cnt_reg == DIV_LAST) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CHECK)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    neg_reg    <= req.sum[wvm_pkg::SUM_W-1];
                    magc_reg   <= magc_in;
                    voices_reg <= req.voices;
                    gain_reg   <= req.gain;
                end
            end
            S_PROD:
            begin
                prod_reg <= magc_reg * gain_reg;
            end
            S_CHECK:
            begin
                if (over)
                begin
                    quo_reg <= SAT_MAX;
                end
                else
                begin
                    rem_reg <= x_val[9:7];
                    dvd_reg <= x_val[6:0];
                    quo_reg <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg <= fits ? 3'(trial - voices_reg) : trial[2:0];
                dvd_reg <= {dvd_reg[5:0], 1'b0};
                quo_reg <= {quo_reg[5:0], fits};
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done   = state_reg == S_DONE;
    assign rsp.sample = neg_reg ? 8'(-{1'b0, quo_reg}) : {1'b0, quo_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE)
        else $error("scaler started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> ({1'b0, rem_reg} < voices_reg))
        else $error("divider remainder not below divisor");

endmodule

// File: rtl/wavetable_voice_mixer.sv
// wavetable_voice_mixer: multi-voice wavetable sound generator, top level
// uses wvm_pkg, wvm_sound_regs, wvm_wave_mem, wvm_scaler
//
// channel   signals                                    direction
// config    psel penable pwrite paddr pwdata prdata    apb slave, 3 registers
// in        in_valid in_stall func addr value          word in
// out       out_valid out_stall sample                 word out
//
// register, enable and wave load words are taken while in_stall stays low
// a tick reads four pairs per active voice on the sound register memory in the nibble map and
//   two in the byte map, then runs a seven-step serial divide that is skipped when the scaled
//   value saturates; a disabled tick goes straight to the output register with a zero sample
// one word in flight; in_stall stays high until its result sits in the output register
// a held output word does not stop the next word from being taken
// reset restores the configuration defaults and clears phases and the valid bits of both memories
module wavetable_voice_mixer #(
    parameter int MAX_VOICE_COUNT = 8,
    parameter int WAVE_ENTRIES    = 256,
    parameter int REG_COUNT       = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [7:0]        addr,
    input  logic [7:0]        value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] sample
);

    localparam int VW  = (MAX_VOICE_COUNT > 1) ? $clog2(MAX_VOICE_COUNT) : 1;
    localparam int WAW = $clog2(WAVE_ENTRIES);
    localparam int PW  = wvm_pkg::PHASE_W;
    localparam int AW  = wvm_pkg::REG_ADDR_W;

    localparam logic [10:0] WMOD1 = 11'(WAVE_ENTRIES);
    localparam logic [10:0] WMOD2 = 11'(2 * WAVE_ENTRIES);
    localparam logic [10:0] WMOD4 = 11'(4 * WAVE_ENTRIES);
    localparam logic [3:0]  MAX_VC = 4'(MAX_VOICE_COUNT);

    localparam logic [AW-1:0] NIB_LOW_REG  = 7'h10;
    localparam logic [AW-1:0] NIB_SEL_BASE = 7'h05;
    localparam logic [AW-1:0] BYTE_BASE    = 7'h03;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_PUT   = 3'd4;

    // configuration and enable
    logic       map_mode_reg;
    logic [3:0] voice_count_reg;
    logic [7:0] mix_gain_reg;
    logic       enabled_reg;
    logic       cfg_wr;
    logic [3:0] active_vc;

    // control
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;
    logic       tick_go;
    logic       put_ok;

    // read issue
    logic          issue_active_reg;
    logic [VW-1:0] issue_voice_reg;
    logic [1:0]    issue_step_reg;
    logic [1:0]    last_step;
    logic          issue_end;
    logic          issue_final;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [7:0]    rdata_a;
    logic [7:0]    rdata_b;

    // collect
    logic          rd_valid_reg;
    logic          rd_end_reg;
    logic          rd_last_reg;
    logic [1:0]    rd_step_reg;
    logic [VW-1:0] rd_voice_reg;
    logic [7:0]    slot_reg [8];
    logic [7:0]    cur [8];
    logic [PW-1:0] dfreq;
    logic [7:0]    dvol;
    logic [2:0]    dsel;

    // decoded voice
    logic          dec_valid_reg;
    logic          dec_last_reg;
    logic [VW-1:0] dec_voice_reg;
    logic [PW-1:0] dec_freq_reg;
    logic [7:0]    dec_vol_reg;
    logic [2:0]    dec_sel_reg;
    logic [PW-1:0] phase_reg [MAX_VOICE_COUNT];
    logic [PW-1:0] phase_sum;
    logic          dec_active;
    logic [10:0]   widx_0;
    logic [10:0]   widx_1;
    logic [10:0]   widx_2;
    logic [10:0]   widx_3;
    logic [wvm_pkg::WAVE_W-1:0] wave_data;

    // wave lookup and multiply
    logic                               ex_valid_reg;
    logic                               ex_last_reg;
    logic                               ex_active_reg;
    logic [7:0]                         ex_vol_reg;
    logic signed [4:0]                  sx;
    logic signed [8:0]                  vx;
    logic signed [13:0]                 prod_full;
    logic                               mul_valid_reg;
    logic                               mul_last_reg;
    logic signed [wvm_pkg::PROD_W-1:0]  mul_prod_reg;
    logic signed [wvm_pkg::SUM_W-1:0]   acc_reg;

    // result
    logic signed [7:0] result_reg;
    logic              out_valid_reg;
    logic signed [7:0] sample_reg;

    wvm_pkg::mem_wr_t  reg_wr;
    wvm_pkg::mem_wr_t  wave_wr;
    wvm_pkg::scl_req_t scl_req;
    wvm_pkg::scl_rsp_t scl_rsp;

    function automatic logic [AW-1:0] slot_addr(input logic mode, input logic [2:0] slot,
                                                 input logic [VW-1:0] v);
        logic [AW-1:0] nb;
        logic [AW-1:0] bb;
        logic [AW-1:0] res;
        nb = AW'({v, 2'b00}) + AW'(v);
        bb = AW'({v, 3'b000});
        if (mode == wvm_pkg::MAP_NIBBLE)
        begin
            if (slot == 3'd0)
                res = NIB_LOW_REG;
            else if (slot == 3'd6 || slot == 3'd7)
                res = NIB_SEL_BASE + nb;
            else
                res = NIB_LOW_REG + AW'(slot) + nb;
        end
        else
        begin
            res = BYTE_BASE + AW'(slot[1:0]) + bb;
        end
        return res;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            wvm_pkg::CFG_MAP_MODE:    prdata = {31'b0, map_mode_reg};
            wvm_pkg::CFG_VOICE_COUNT: prdata = {28'b0, voice_count_reg};
            wvm_pkg::CFG_MIX_GAIN:    prdata = {24'b0, mix_gain_reg};
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        if (voice_count_reg == 4'd0)
            active_vc = 4'd1;
        else if (voice_count_reg > MAX_VC)
            active_vc = MAX_VC;
        else
            active_vc = voice_count_reg;
    end

    // input side
    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign tick_go  = accept && (func == wvm_pkg::FUNC_TICK) && enabled_reg;
    assign put_ok   = !out_valid_reg || !out_stall;

    always_comb
    begin
        reg_wr.en    = accept && (func == wvm_pkg::FUNC_REG_WR);
        reg_wr.addr  = addr;
        reg_wr.data  = (map_mode_reg == wvm_pkg::MAP_NIBBLE) ? {4'h0, value[3:0]} : value;
        wave_wr.en   = accept && (func == wvm_pkg::FUNC_WAVE_LD);
        wave_wr.addr = addr;
        wave_wr.data = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= wvm_pkg::RST_MAP_MODE;
            voice_count_reg <= wvm_pkg::RST_VOICE_COUNT;
            mix_gain_reg    <= wvm_pkg::RST_MIX_GAIN;
            enabled_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    wvm_pkg::CFG_MAP_MODE:    map_mode_reg    <= pwdata[0];
                    wvm_pkg::CFG_VOICE_COUNT: voice_count_reg <= pwdata[3:0];
                    wvm_pkg::CFG_MIX_GAIN:    mix_gain_reg    <= pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept && func == wvm_pkg::FUNC_ENABLE)
            begin
                enabled_reg <= ((map_mode_reg == wvm_pkg::MAP_NIBBLE) ? value : addr) != 8'h00;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && func == wvm_pkg::FUNC_TICK)
                    state_next = enabled_reg ? ST_RUN : ST_PUT;
            ST_RUN:   if (mul_valid_reg && mul_last_reg) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_WAIT;
            ST_WAIT:  if (scl_rsp.done) state_next = ST_PUT;
            ST_PUT:   if (put_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // read issue: two sound register slots per cycle
    assign last_step   = (map_mode_reg == wvm_pkg::MAP_NIBBLE) ? 2'd3 : 2'd1;
    assign issue_end   = issue_step_reg == last_step;
    assign issue_final = issue_end && (4'(issue_voice_reg) == active_vc - 4'd1);
    assign raddr_a     = slot_addr(map_mode_reg, {issue_step_reg, 1'b0}, issue_voice_reg);
    assign raddr_b     = slot_addr(map_mode_reg, {issue_step_reg, 1'b1}, issue_voice_reg);

    wvm_sound_regs #(
        .REG_COUNT (REG_COUNT)
    ) u_sound_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (reg_wr),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // collect slots and decode one voice
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cur[i] = slot_reg[i];
        end
        cur[{rd_step_reg, 1'b0}] = rdata_a;
        cur[{rd_step_reg, 1'b1}] = rdata_b;

        if (map_mode_reg == wvm_pkg::MAP_NIBBLE)
        begin
            dfreq = {cur[4][3:0], cur[3][3:0], cur[2][3:0], cur[1][3:0],
                     (rd_voice_reg == '0) ? cur[0][3:0] : 4'h0};
            dvol  = {4'h0, cur[5][3:0]};
            dsel  = cur[6][2:0];
        end
        else
        begin
            dfreq = {cur[3][3:0], cur[2], cur[1]};
            dvol  = cur[0];
            dsel  = cur[3][6:4];
        end
    end

    // phase update and wave address, modulo the table size
    always_comb
    begin
        phase_sum  = phase_reg[dec_voice_reg] + dec_freq_reg;
        dec_active = (dec_freq_reg != '0) && (dec_vol_reg != 8'h00);
        widx_0     = {3'b000, dec_sel_reg, phase_sum[PW-1:PW-5]};
        widx_1     = (widx_0 >= WMOD4) ? widx_0 - WMOD4 : widx_0;
        widx_2     = (widx_1 >= WMOD2) ? widx_1 - WMOD2 : widx_1;
        widx_3     = (widx_2 >= WMOD1) ? widx_2 - WMOD1 : widx_2;
    end

    wvm_wave_mem #(
        .WAVE_ENTRIES (WAVE_ENTRIES)
    ) u_wave_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wave_wr),
        .raddr (widx_3[WAW-1:0]),
        .rdata (wave_data)
    );

    assign sx        = $signed({1'b0, wave_data}) - 5'sd8;
    assign vx        = $signed({1'b0, ex_vol_reg});
    assign prod_full = sx * vx;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_active_reg <= 1'b0;
            issue_voice_reg  <= '0;
            issue_step_reg   <= '0;
            rd_valid_reg     <= 1'b0;
            rd_end_reg       <= 1'b0;
            rd_last_reg      <= 1'b0;
            dec_valid_reg    <= 1'b0;
            dec_last_reg     <= 1'b0;
            ex_valid_reg     <= 1'b0;
            ex_last_reg      <= 1'b0;
            mul_valid_reg    <= 1'b0;
            mul_last_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_VOICE_COUNT; i++)
            begin
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (tick_go)
            begin
                issue_active_reg <= 1'b1;
                issue_voice_reg  <= '0;
                issue_step_reg   <= '0;
            end
            else if (issue_active_reg)
            begin
                if (issue_end)
                begin
                    issue_step_reg  <= '0;
                    issue_voice_reg <= issue_voice_reg + VW'(1);
                    if (issue_final)
                    begin
                        issue_active_reg <= 1'b0;
                    end
                end
                else
                begin
                    issue_step_reg <= issue_step_reg + 2'd1;
                end
            end

            rd_valid_reg  <= issue_active_reg;
            rd_end_reg    <= issue_end;
            rd_last_reg   <= issue_final;
            dec_valid_reg <= rd_valid_reg && rd_end_reg;
            dec_last_reg  <= rd_last_reg;
            ex_valid_reg  <= dec_valid_reg;
            ex_last_reg   <= dec_last_reg;
            mul_valid_reg <= ex_valid_reg;
            mul_last_reg  <= ex_last_reg;

            if (dec_valid_reg && dec_active)
            begin
                phase_reg[dec_voice_reg] <= phase_sum;
            end

            if (state_reg == ST_PUT && put_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_step_reg  <= issue_step_reg;
        rd_voice_reg <= issue_voice_reg;
        if (rd_valid_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                slot_reg[i] <= cur[i];
            end
        end

        dec_voice_reg <= rd_voice_reg;
        dec_freq_reg  <= dfreq;
        dec_vol_reg   <= dvol;
        dec_sel_reg   <= dsel;

        ex_active_reg <= dec_active;
        ex_vol_reg    <= dec_vol_reg;

        mul_prod_reg <= ex_active_reg ? prod_full[wvm_pkg::PROD_W-1:0] : '0;

        if (tick_go)
        begin
            acc_reg <= '0;
        end
        else if (mul_valid_reg)
        begin
            acc_reg <= acc_reg + {{(wvm_pkg::SUM_W - wvm_pkg::PROD_W){mul_prod_reg[wvm_pkg::PROD_W-1]}},
                                  mul_prod_reg};
        end

        if (accept && func == wvm_pkg::FUNC_TICK && !enabled_reg)
        begin
            result_reg <= '0;
        end
        else if (state_reg == ST_WAIT && scl_rsp.done)
        begin
            result_reg <= scl_rsp.sample;
        end

        if (state_reg == ST_PUT && put_ok)
        begin
            sample_reg <= result_reg;
        end
    end

    // gain and scale
    always_comb
    begin
        scl_req.start  = state_reg == ST_SCALE;
        scl_req.sum    = acc_reg;
        scl_req.voices = active_vc;
        scl_req.gain   = mix_gain_reg;
    end

    wvm_scaler u_scaler (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scl_req),
        .rsp   (scl_rsp)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid_reg |-> state_reg == ST_RUN)
        else $error("voice decoded outside a running tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && mul_last_reg) |=> state_reg == ST_SCALE)
        else $error("last voice product did not start scaling");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == wvm_pkg::FUNC_TICK && !enabled_reg)
        |=> (state_reg == ST_PUT && result_reg == 8'sd0))
        else $error("disabled tick did not yield zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sample_reg != 8'sh80)
        else $error("output word beyond clamp range");

endmodule

// File: tb/wavetable_voice_mixer_tb.sv
// wavetable_voice_mixer_tb: self-checking bench for the wavetable voice mixer
// predicts every tick sample from its own copy of the register file, wave table and phases
// depends on wvm_pkg and the wavetable_voice_mixer rtl only
`timescale 1ns / 100ps

module wavetable_voice_mixer_tb;

    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 162;
    localparam int REGS            = 64;
    localparam int WAVES           = 256;
    localparam int VOICES_MAX      = 8;

    // nibble map offsets, voice stride 5
    localparam int NIB_WAVE_SEL = 'h05;
    localparam int NIB_FREQ_N0  = 'h10;
    localparam int NIB_FREQ_N1  = 'h11;
    localparam int NIB_FREQ_N2  = 'h12;
    localparam int NIB_FREQ_N3  = 'h13;
    localparam int NIB_FREQ_N4  = 'h14;
    localparam int NIB_VOLUME   = 'h15;
    localparam int NIB_STRIDE   = 5;
    // byte map offsets, voice stride 8
    localparam int BYTE_VOLUME  = 'h03;
    localparam int BYTE_FREQ_LO = 'h04;
    localparam int BYTE_FREQ_MI = 'h05;
    localparam int BYTE_FREQ_HS = 'h06;
    localparam int BYTE_STRIDE  = 8;

    class sample_scoreboard;
        bit                byte_map;
        bit [3:0]          voice_cnt;
        bit [7:0]          gain;
        bit [7:0]          sound_reg [REGS];
        bit [3:0]          wave [WAVES];
        bit [19:0]         phase_acc [VOICES_MAX];
        bit                sound_on;
        logic signed [7:0] expected_samples [$];
        int                mismatches;
        int                samples_checked;

        function new();
            byte_map  = wvm_pkg::RST_MAP_MODE;
            voice_cnt = wvm_pkg::RST_VOICE_COUNT;
            gain      = wvm_pkg::RST_MIX_GAIN;
            foreach (sound_reg[i]) sound_reg[i] = '0;
            foreach (wave[i]) wave[i] = '0;
            foreach (phase_acc[i]) phase_acc[i] = '0;
            sound_on        = 1'b1;
            mismatches      = 0;
            samples_checked = 0;
        endfunction

        function void set_config(input logic [1:0] index, input logic [7:0] data);
            case (index)
                wvm_pkg::CFG_MAP_MODE:    byte_map  = data[0];
                wvm_pkg::CFG_VOICE_COUNT: voice_cnt = data[3:0];
                wvm_pkg::CFG_MIX_GAIN:    gain      = data;
                default: ;
            endcase
        endfunction

        function bit [7:0] reg_at(input int idx);
            return (idx < REGS) ? sound_reg[idx] : 8'd0;
        endfunction

        function logic signed [7:0] mix_tick_sample();
            int        nv;
            int        sum;
            int        mag;
            int        lim;
            int        scaled;
            int        base;
            bit [19:0] freq;
            bit [19:0] step;
            bit [7:0]  vol;
            bit [7:0]  hi;
            bit [2:0]  sel;
            bit [7:0]  widx;
            bit [3:0]  n0;
            if (!sound_on)
                return 8'sd0;
            nv = (voice_cnt == 0) ? 1 : (voice_cnt > VOICES_MAX) ? VOICES_MAX : int'(voice_cnt);
            sum = 0;
            for (int v = 0; v < nv; v++)
            begin
                if (!byte_map)
                begin
                    base = NIB_STRIDE * v;
                    n0   = (v == 0) ? 4'(reg_at(NIB_FREQ_N0)) : 4'h0;
                    freq = {4'(reg_at(NIB_FREQ_N4 + base)), 4'(reg_at(NIB_FREQ_N3 + base)),
                            4'(reg_at(NIB_FREQ_N2 + base)), 4'(reg_at(NIB_FREQ_N1 + base)), n0};
                    vol  = {4'h0, 4'(reg_at(NIB_VOLUME + base))};
                    sel  = 3'(reg_at(NIB_WAVE_SEL + base));
                end
                else
                begin
                    base = BYTE_STRIDE * v;
                    hi   = reg_at(BYTE_FREQ_HS + base);
                    freq = {hi[3:0], reg_at(BYTE_FREQ_MI + base), reg_at(BYTE_FREQ_LO + base)};
                    vol  = reg_at(BYTE_VOLUME + base);
                    sel  = hi[6:4];
                end
                if (freq != 0 && vol != 0)
                begin
                    step         = phase_acc[v] + freq;
                    widx         = {sel, step[19:15]};
                    phase_acc[v] = step;
                    sum += (int'(wave[widx]) - 8) * int'(vol);
                end
            end
            mag = (sum < 0) ? -sum : sum;
            lim = nv * 128;
            if (mag >= lim)
                mag = lim - 1;
            scaled = (mag * int'(gain)) / (nv * 16);
            if (scaled > 127)
                scaled = 127;
            return (sum < 0) ? 8'(-scaled) : 8'(scaled);
        endfunction

        function void note_word(input logic [1:0] f, input logic [7:0] a, input logic [7:0] d);
            case (f)
                wvm_pkg::FUNC_TICK:
                    expected_samples.push_back(mix_tick_sample());
                wvm_pkg::FUNC_REG_WR:
                    if (int'(a) < REGS)
                        sound_reg[a] = byte_map ? d : {4'h0, d[3:0]};
                wvm_pkg::FUNC_ENABLE:
                    sound_on = byte_map ? (a != 0) : (d != 0);
                wvm_pkg::FUNC_WAVE_LD:
                    if (int'(a) < WAVES)
                        wave[a] = d[3:0];
                default: ;
            endcase
        endfunction

        function void check_sample(input logic signed [7:0] got);
            logic signed [7:0] want;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                $display("%0t: sample %0d arrived, expected none", $time, got);
                return;
            end
            want = expected_samples.pop_front();
            samples_checked++;
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [3:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        func      = wvm_pkg::FUNC_TICK;
    logic [7:0]        addr      = '0;
    logic [7:0]        value     = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [7:0] sample;

    sample_scoreboard sb = new();
    int send_idle_pct  = 10;
    int recv_stall_pct = 71;
    int words_by_func [4] = '{0, 0, 0, 0};

    wavetable_voice_mixer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .addr      (addr),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic apb_write(input logic [1:0] index, input logic [7:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'($urandom()), data};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_config(index, data);
        @(posedge clk);
    endtask

    task automatic configure(input bit bm, input bit [3:0] vc, input bit [7:0] g);
        apb_write(wvm_pkg::CFG_MAP_MODE, {7'd0, bm});
        apb_write(wvm_pkg::CFG_VOICE_COUNT, {4'd0, vc});
        apb_write(wvm_pkg::CFG_MIX_GAIN, g);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(input logic [1:0] f, input logic [7:0] a, input logic [7:0] d);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        addr     <= a;
        value    <= d;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_word(f, a, d);
        words_by_func[f]++;
    endtask

    task automatic send_random_word();
        int         pick;
        bit         enabling;
        logic [7:0] a;
        logic [7:0] d;
        pick = $urandom_range(99);
        a    = 8'($urandom());
        d    = 8'($urandom());
        if (pick < 40)
            send_word(wvm_pkg::FUNC_TICK, a, d);
        else if (pick < 70)
        begin
            if ($urandom_range(9) < 8)
                a = 8'($urandom_range(REGS - 1));
            send_word(wvm_pkg::FUNC_REG_WR, a, d);
        end
        else if (pick < 90)
            send_word(wvm_pkg::FUNC_WAVE_LD, a, d);
        else
        begin
            enabling = ($urandom_range(9) != 0);
            if (sb.byte_map)
                a = enabling ? 8'($urandom_range(1, 255)) : 8'd0;
            else
                d = enabling ? 8'($urandom_range(1, 255)) : 8'd0;
            send_word(wvm_pkg::FUNC_ENABLE, a, d);
        end
    endtask

    // receiving side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_sample(sample);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: cycle limit reached, %0d samples outstanding", $time,
                 sb.expected_samples.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int phase_idx;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nibble map, three voices
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_WAVE_LD, 8'h00, 8'hff);
        send_word(wvm_pkg::FUNC_WAVE_LD, 8'hff, 8'h00);
        send_word(wvm_pkg::FUNC_WAVE_LD, 8'h01, 8'hf0);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_FREQ_N0), 8'hff);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_VOLUME), 8'h0f);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_WAVE_SEL), 8'h00);
        send_word(wvm_pkg::FUNC_TICK, 8'hff, 8'hff);
        send_word(wvm_pkg::FUNC_REG_WR, 8'h40, 8'hff);
        send_word(wvm_pkg::FUNC_REG_WR, 8'hff, 8'h0f);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_FREQ_N4), 8'h0f);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_ENABLE, 8'hff, 8'h00);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_ENABLE, 8'h00, 8'h80);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_VOLUME + NIB_STRIDE), 8'h0f);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_FREQ_N4 + NIB_STRIDE), 8'h0f);
        send_word(wvm_pkg::FUNC_REG_WR, 8'(NIB_WAVE_SEL + NIB_STRIDE), 8'h07);
        send_word(wvm_pkg::FUNC_WAVE_LD, 8'h80, 8'h08);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        send_word(wvm_pkg::FUNC_TICK, 8'h00, 8'h00);
        wait_idle();

        for (phase_idx = 0; phase_idx < PHASES; phase_idx++)
        begin
            case (phase_idx * 3 / PHASES)
                0:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 71;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 10;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (phase_idx)
                0: configure(1'b1, 4'd8, 8'd255);
                1: configure(1'b0, 4'd0, 8'd0);
                2: configure(1'b1, 4'd15, 8'd1);
                3: configure(1'b0, 4'd8, 8'd255);
                4: configure(1'b1, 4'd1, 8'd16);
                5: configure(1'b1, 4'd9, 8'd200);
                default: configure(1'($urandom()), 4'($urandom()), 8'($urandom()));
            endcase
            repeat (WORDS_PER_PHASE) send_random_word();
            wait_idle();
        end

        $display("sent %0d ticks, %0d register writes, %0d enable writes, %0d wave loads",
                 words_by_func[wvm_pkg::FUNC_TICK], words_by_func[wvm_pkg::FUNC_REG_WR],
                 words_by_func[wvm_pkg::FUNC_ENABLE], words_by_func[wvm_pkg::FUNC_WAVE_LD]);
        $display("%0d samples checked over %0d mixer settings, %0d mismatches",
                 sb.samples_checked, PHASES + 1, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_samples.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
